FILE: rtl/best_fit_free_list_defines.svh
// Assertion macros shared by the free-list RTL.
`ifndef BEST_FIT_FREE_LIST_DEFINES_SVH
`define BEST_FIT_FREE_LIST_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on every rising edge of clk_i outside reset.
`define BFFL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("free list assertion failed");
// Check an implication on every rising edge of clk_i outside reset.
`define BFFL_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("free list implication failed");
`else
`define BFFL_ASSERT(lbl, prop)
`define BFFL_ASSERT_IMPL(lbl, pre, post)
`endif

`endif

FILE: rtl/bffl_pkg.sv
// Types and constants of the best-fit free list.
`timescale 1ns / 1ps
`default_nettype none
package bffl_pkg;

  localparam int OP_W  = 2;
  localparam int OFF_W = 32;
  localparam int LEN_W = 16;
  localparam int ENT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND     = 2'd0,
    OP_INS_BEFORE = 2'd1,
    OP_INS_AFTER  = 2'd2,
    OP_TAKE       = 2'd3
  } op_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
  } entry_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic             capture;
    logic             apply;
    op_e              op;
    logic [LEN_W-1:0] len;
    logic [OFF_W-1:0] off;
  } ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/bffl_in_if.sv
// Request channel: one operation per word.
`timescale 1ns / 1ps
`default_nettype none
interface bffl_in_if;
  import bffl_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [OFF_W-1:0] hole_offset;
  logic [LEN_W-1:0] hole_length;

  modport source (output valid, op, hole_offset, hole_length, input ready);
  modport sink   (input valid, op, hole_offset, hole_length, output ready);
endinterface
`default_nettype wire

FILE: rtl/bffl_out_if.sv
// Result channel: one word per request.
`timescale 1ns / 1ps
`default_nettype none
interface bffl_out_if;
  import bffl_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic [OFF_W-1:0] offset_out;
  logic             full_res;
  logic [ENT_W-1:0] entries;

  modport source (output valid, found, offset_out, full_res, entries, input ready);
  modport sink   (input valid, found, offset_out, full_res, entries, output ready);
endinterface
`default_nettype wire

FILE: rtl/bffl_cell.sv
// One slot of the hole list: compare, priority link and shift.
`timescale 1ns / 1ps
`default_nettype none
module bffl_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire bffl_pkg::ctrl_t    ctrl_i,
  input  wire         [CNT_W-1:0] count_i,
  input  wire bffl_pkg::entry_t   left_i,
  input  wire bffl_pkg::entry_t   right_i,
  input  wire                     before_i,
  output logic                    before_o,
  output logic                    hit_o,
  output bffl_pkg::entry_t        data_o
);
  import bffl_pkg::*;

  localparam logic [CNT_W-1:0] IdxC = CNT_W'(IDX);

  entry_t ent_q;
  logic   occ;
  logic   m_d, m_q;

  assign occ = (IdxC < count_i);

  always_comb begin
    case (ctrl_i.op)
      OP_TAKE:       m_d = occ && (ent_q.len >= ctrl_i.len);
      OP_INS_BEFORE: m_d = !occ || (ent_q.len >= ctrl_i.len);
      OP_INS_AFTER:  m_d = !occ || (ent_q.len > ctrl_i.len);
      default:       m_d = !occ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_q <= 1'b0;
    end else if (ctrl_i.capture) begin
      m_q <= m_d;
    end
  end

  // Take closes the gap from the right; inserts open one from the left.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.apply) begin
      if (ctrl_i.op == OP_TAKE) begin
        if (before_i || m_q) ent_q <= right_i;
      end else if (before_i) begin
        ent_q <= left_i;
      end else if (m_q) begin
        ent_q <= '{off: ctrl_i.off, len: ctrl_i.len};
      end
    end
  end

  assign before_o = before_i | m_q;
  assign hit_o    = m_q & ~before_i;
  assign data_o   = ent_q;

endmodule
`default_nettype wire

FILE: rtl/bffl_chain.sv
// Row of list cells with the first-match link and offset select.
`timescale 1ns / 1ps
`default_nettype none
module bffl_chain #(
  parameter int DEPTH = 64,
  parameter int CNT_W = 7
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire bffl_pkg::ctrl_t         ctrl_i,
  input  wire              [CNT_W-1:0] count_i,
  output logic                         any_o,
  output logic [bffl_pkg::OFF_W-1:0]   hit_off_o
);
  import bffl_pkg::*;

  entry_t               data [DEPTH];
  logic   [DEPTH:0]     prior;
  logic   [DEPTH-1:0]   hit;
  logic   [OFF_W-1:0]   sel [DEPTH+1];

  assign prior[0] = 1'b0;
  assign sel[0]   = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left, right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = data[i+1];
    end

    bffl_cell #(.IDX(i), .CNT_W(CNT_W)) u_cell (
      .clk_i,
      .rst_ni,
      .ctrl_i,
      .count_i,
      .left_i   (left),
      .right_i  (right),
      .before_i (prior[i]),
      .before_o (prior[i+1]),
      .hit_o    (hit[i]),
      .data_o   (data[i])
    );

    assign sel[i+1] = sel[i] | (hit[i] ? data[i].off : '0);
  end

  assign any_o     = prior[DEPTH];
  assign hit_off_o = sel[DEPTH];

endmodule
`default_nettype wire

FILE: rtl/best_fit_free_list.sv
// Top level of the best-fit free list.
`timescale 1ns / 1ps
`default_nettype none
`include "best_fit_free_list_defines.svh"
// Best-fit free list: holds up to DEPTH holes (offset, length) in list order,
// one per cell of a shifting chain. Each request is handled as follows: in the
// accept cycle all cells compare their length against the request and register
// the result; in the execute state the first-match link through the chain picks
// the position, the cells shift by one (not for a take that finds no hole or an
// insert into a full list) and the result word is loaded into the output
// register. A new request is accepted while that result waits, one request at
// a time. Execute holds only while the output register holds an untaken word.
module best_fit_free_list #(
  parameter int DEPTH = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  bffl_in_if.sink     in_i,
  bffl_out_if.source  out_o
);
  import bffl_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DepthC = CNT_W'(DEPTH);

  state_e             state_q, state_d;
  op_e                op_q;
  logic [OFF_W-1:0]   off_q;
  logic [LEN_W-1:0]   len_q;
  logic [CNT_W-1:0]   count_q, count_d;
  ctrl_t              ctrl;
  logic               in_fire, commit, is_take, is_full, any;
  logic [OFF_W-1:0]   hit_off;

  logic               out_valid_q, found_q, full_q;
  logic [OFF_W-1:0]   offset_q;
  logic [ENT_W-1:0]   entries_q;

  assign in_fire = in_i.valid && in_i.ready;
  assign is_take = (op_q == OP_TAKE);
  assign is_full = (count_q == DepthC);

  always_comb begin
    unique case (state_q)
      S_IDLE:  state_d = in_fire ? S_EXEC : S_IDLE;
      S_EXEC:  state_d = commit ? S_IDLE : S_EXEC;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = 1'b0;
    commit     = 1'b0;
    unique case (state_q)
      S_IDLE:  in_i.ready = 1'b1;
      S_EXEC:  commit = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  // Cells compare against the incoming word, then update with the held one.
  always_comb begin
    ctrl.capture = in_fire;
    ctrl.apply   = commit && (is_take || !is_full);
    if (state_q == S_IDLE) begin
      ctrl.op  = op_e'(in_i.op);
      ctrl.len = in_i.hole_length;
    end else begin
      ctrl.op  = op_q;
      ctrl.len = len_q;
    end
    ctrl.off = off_q;
  end

  bffl_chain #(.DEPTH(DEPTH), .CNT_W(CNT_W)) u_chain (
    .clk_i,
    .rst_ni,
    .ctrl_i    (ctrl),
    .count_i   (count_q),
    .any_o     (any),
    .hit_off_o (hit_off)
  );

  always_comb begin
    count_d = count_q;
    if (commit) begin
      if (is_take) begin
        if (any) count_d = count_q - CNT_W'(1);
      end else if (!is_full) begin
        count_d = count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= op_e'(in_i.op);
      off_q <= in_i.hole_offset;
      len_q <= in_i.hole_length;
    end
    if (commit) begin
      found_q   <= is_take && any;
      offset_q  <= (is_take && any) ? hit_off : '0;
      full_q    <= !is_take && is_full;
      entries_q <= ENT_W'(count_d);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.found      = found_q;
  assign out_o.offset_out = offset_q;
  assign out_o.full_res   = full_q;
  assign out_o.entries    = entries_q;

  `BFFL_ASSERT(a_count_bound, count_q <= DepthC)
  `BFFL_ASSERT_IMPL(a_found_not_full, out_o.valid, !(out_o.found && out_o.full_res))
  `BFFL_ASSERT_IMPL(a_take_dec, commit && is_take && any, ##1 count_q == $past(count_q) - CNT_W'(1))
  `BFFL_ASSERT_IMPL(a_full_hold, commit && !is_take && is_full, ##1 count_q == $past(count_q))

endmodule
`default_nettype wire

FILE: tb/tb_best_fit_free_list.sv
// Self-checking testbench for the best-fit free list: shadow table, random traffic and stalls.
`timescale 1ns / 1ps
module tb_best_fit_free_list;
  import bffl_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int RANDOM_WORDS = 200;

  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] offset_out;
    logic             full_res;
    logic [ENT_W-1:0] entries;
  } result_word_t;

  logic clk_i;
  logic rst_ni;

  bffl_in_if  in_if ();
  bffl_out_if out_if ();

  best_fit_free_list #(
    .DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  entry_t       free_holes[$];
  result_word_t pending_words[$];
  int           mismatch_cnt = 0;
  bit           tx_steady = 1'b0;
  bit           rx_steady = 1'b0;
  int           rx_hold = 0;
  int           rx_stall = 0;

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [OFF_W-1:0] got,
                                 input logic [OFF_W-1:0] want);
    mismatch_cnt++;
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Favor a few small lengths so ties and hits are common.
  function automatic logic [LEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return LEN_W'($urandom_range(0, 7) * 16);
    if (r < 55) return ($urandom_range(0, 1) != 0) ? {LEN_W{1'b1}} : '0;
    return LEN_W'($urandom_range(0, 65535));
  endfunction

  // Advance the shadow table by one operation and queue the word it should return.
  function automatic void predict_hole_op(input op_e op, input logic [OFF_W-1:0] off,
                                          input logic [LEN_W-1:0] len);
    result_word_t w;
    entry_t       e;
    int           pos;
    w = '0;
    if (op == OP_TAKE) begin
      pos = -1;
      for (int i = 0; i < free_holes.size(); i++) begin
        if (free_holes[i].len >= len) begin
          pos = i;
          break;
        end
      end
      if (pos >= 0) begin
        w.found      = 1'b1;
        w.offset_out = free_holes[pos].off;
        free_holes.delete(pos);
      end
    end else if (free_holes.size() >= TABLE_DEPTH) begin
      w.full_res = 1'b1;
    end else begin
      pos = free_holes.size();
      for (int i = 0; i < free_holes.size(); i++) begin
        if ((op == OP_INS_BEFORE && free_holes[i].len >= len) ||
            (op == OP_INS_AFTER && free_holes[i].len > len)) begin
          pos = i;
          break;
        end
      end
      e.off = off;
      e.len = len;
      free_holes.insert(pos, e);
    end
    w.entries = ENT_W'(free_holes.size());
    pending_words.push_back(w);
  endfunction

  // Called at a falling edge; returns at a falling edge.
  task automatic send_word(input op_e op, input logic [OFF_W-1:0] off,
                           input logic [LEN_W-1:0] len);
    int gap;
    in_if.valid       = 1'b1;
    in_if.op          = op;
    in_if.hole_offset = off;
    in_if.hole_length = len;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_hole_op(op, off, len);
    @(negedge clk_i);
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_random_word();
    op_e op;
    int  take_pct;
    take_pct = 15 + free_holes.size();
    if ($urandom_range(0, 99) < take_pct) op = OP_TAKE;
    else op = op_e'($urandom_range(0, 2));
    send_word(op, $urandom, pick_length());
  endtask

  // Hold the input idle until every queued word has come back, then let the pipe settle.
  task automatic drain_results();
    in_if.valid = 1'b0;
    while (pending_words.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_word(OP_TAKE, 32'h0, 16'h0);
    send_word(OP_TAKE, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(OP_APPEND, 32'h0, 16'h0);
    send_word(OP_APPEND, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(OP_APPEND, 32'h11, 16'd100);
    send_word(OP_INS_BEFORE, 32'h22, 16'd100);
    send_word(OP_INS_AFTER, 32'h33, 16'd100);
    send_word(OP_INS_BEFORE, 32'h44, 16'd0);
    send_word(OP_INS_AFTER, 32'h55, 16'd0);
    send_word(OP_TAKE, 32'h0, 16'd100);
    send_word(OP_TAKE, 32'h0, 16'd101);
    send_word(OP_TAKE, 32'h0, 16'd0);
    send_word(OP_TAKE, 32'h0, 16'hFFFF);
    send_word(OP_TAKE, 32'h0, 16'hFFFF);
    send_word(OP_INS_AFTER, 32'hA5A5_A5A5, 16'hFFFF);
    send_word(OP_INS_BEFORE, 32'h5A5A_5A5A, 16'hFFFF);
    send_word(OP_TAKE, 32'hFFFF_FFFF, 16'hFFFF);
    while (free_holes.size() != 0) send_word(OP_TAKE, 32'h0, 16'h0);
    send_word(OP_TAKE, 32'h0, 16'h0);
    drain_results();
  endtask

  task automatic test_full_table();
    while (free_holes.size() < TABLE_DEPTH)
      send_word(op_e'($urandom_range(0, 2)), $urandom, pick_length());
    send_word(OP_APPEND, $urandom, pick_length());
    send_word(OP_INS_BEFORE, $urandom, 16'h0);
    send_word(OP_INS_AFTER, $urandom, 16'hFFFF);
    send_word(OP_TAKE, 32'h0, 16'h0);
    send_word(OP_INS_AFTER, $urandom, pick_length());
    send_word(OP_INS_BEFORE, $urandom, pick_length());
    while (free_holes.size() != 0) send_word(OP_TAKE, $urandom, 16'h0);
    send_word(OP_TAKE, $urandom, 16'h0);
    drain_results();
  endtask

  // Block the result side for a long stretch while words keep coming.
  task automatic test_hold_off();
    tx_steady = 1'b1;
    rx_hold   = 150;
    repeat (30) send_random_word();
    tx_steady = 1'b0;
    drain_results();
  endtask

  task automatic test_random();
    for (int k = 0; k < RANDOM_WORDS / 50; k++) begin
      tx_steady = (k % 4 == 1);
      rx_steady = (k % 4 == 1) || (k % 4 == 2);
      repeat (50) send_random_word();
      if (k % 2 == 1) drain_results();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Result side: random stalls, plus the long hold-off on request.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        out_if.ready = 1'b0;
        rx_hold--;
      end else if (rx_stall > 0) begin
        out_if.ready = 1'b0;
        rx_stall--;
      end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
        out_if.ready = 1'b0;
        rx_stall     = pick_gap();
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    result_word_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", out_if.offset_out, '0);
      end else begin
        want = pending_words.pop_front();
        if (out_if.found !== want.found)
          report_mismatch("found", OFF_W'(out_if.found), OFF_W'(want.found));
        if (out_if.offset_out !== want.offset_out)
          report_mismatch("offset_out", out_if.offset_out, want.offset_out);
        if (out_if.full_res !== want.full_res)
          report_mismatch("full_res", OFF_W'(out_if.full_res), OFF_W'(want.full_res));
        if (out_if.entries !== want.entries)
          report_mismatch("entries", OFF_W'(out_if.entries), OFF_W'(want.entries));
      end
    end
  end

  initial begin
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.op          = OP_APPEND;
    in_if.hole_offset = '0;
    in_if.hole_length = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    test_directed();
    test_full_table();
    test_hold_off();
    test_random();

    drain_results();
    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
